>>> rtl/etxf_pkg.sv
// Shared types and constants of the Ethernet transmit framer.
package etxf_pkg;

    localparam int MAC_W     = 48;
    localparam int TYPE_W    = 16;
    localparam int LEN_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = MAC_W;

    localparam int HDR_BYTES = 14;
    localparam int HDR_W     = HDR_BYTES * BYTE_W;
    localparam int IDX_W     = 4;
    localparam int FCS_BYTES = 4;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1500;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAD,
        ST_FCS
    } t_state;

    typedef struct packed {
        logic [MAC_W-1:0] station_addr;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

    // Reflected CRC-32, one byte, least significant bit first.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/etxf_ifs.sv
// Channel interfaces: input items, frame bytes and configuration writes.
interface etxf_in_if import etxf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [MAC_W-1:0]  dest_mac;
    logic [TYPE_W-1:0] ether_type;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, cmd, dest_mac, ether_type, payload_len, data_byte,
                    input ready);
    modport sink   (input valid, cmd, dest_mac, ether_type, payload_len, data_byte,
                    output ready);
endinterface

interface etxf_out_if import etxf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              end_of_frame;
    logic              oversize_error;

    modport source (output valid, frame_byte, end_of_frame, oversize_error, input ready);
    modport sink   (input valid, frame_byte, end_of_frame, oversize_error, output ready);
endinterface

interface etxf_cfg_if import etxf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/etxf_cfg_regs.sv
// Configuration register file: station address and maximum payload length.
module etxf_cfg_regs import etxf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    etxf_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.station_addr <= '0;
            r_cfg.max_len      <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STATION_ADDR: r_cfg.station_addr <= i_cfg.data;
                CFG_MAX_LEN:      r_cfg.max_len      <= i_cfg.data[LEN_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

endmodule

>>> rtl/ethernet_tx_framer_crc32_core.sv
// Ethernet transmit framer: header build, payload pass-through, padding and FCS.
//
// Channels: i_in takes items; a start item (cmd 0) carries destination address,
// EtherType and payload length, a data item (cmd 1) carries one payload byte.
// o_out gives one frame byte per beat in wire order with end_of_frame on the
// last FCS byte. A start whose length exceeds the maximum gives one beat with
// frame byte 0, end_of_frame and oversize_error set, and the data beats of that
// frame are dropped. i_cfg writes the station address (index 0) and the
// maximum payload length (index 1), one write per cycle, always ready.
// Path: a payload byte passes the input register, then the result register;
// a start passes the input register and the header state before the first
// header byte enters the result register. Throughput while o_out is not held:
// one payload byte per cycle; a start occupies the byte engine for the hand-over
// plus 14 header bytes, the frame end for padding up to MIN_PAYLOAD bytes plus
// 4 FCS bytes at one byte a cycle, as the engine makes at most one byte per cycle.
// Reset: no frame open, CRC preset to all ones, address 0, maximum 1500.
// Stall: while o_out is held the engine halts; one further input beat is
// taken into the input register and waits there.
module ethernet_tx_framer_crc32_core import etxf_pkg::*; #(
    parameter int MIN_PAYLOAD = 46
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    etxf_cfg_if.sink   i_cfg,
    etxf_in_if.sink    i_in,
    etxf_out_if.source o_out
);

    localparam int CNT_W = (MIN_PAYLOAD > 2) ? $clog2(MIN_PAYLOAD) : 1;

    t_cfg w_cfg;

    etxf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input holding register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [MAC_W-1:0]  r_in_dest;
    logic [TYPE_W-1:0] r_in_type;
    logic [LEN_W-1:0]  r_in_len;
    logic [BYTE_W-1:0] r_in_data;

    // frame engine
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [HDR_W-1:0]  r_hdr, n_hdr;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_seen, n_seen;
    logic              r_open, n_open;
    logic [CRC_W-1:0]  r_crc, n_crc;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_eof;
    logic              r_out_err;

    logic              w_out_free;
    logic              w_take;
    logic              w_oversize;
    logic [LEN_W-1:0]  w_seen_inc;
    logic              w_seen_done;
    logic              w_need_pad;
    logic              w_hdr_last;
    logic              w_pad_last;
    logic              w_fcs_last;
    logic [CRC_W-1:0]  w_fcs_sh;
    logic              w_emit;
    logic [BYTE_W-1:0] w_emit_byte;
    logic              w_emit_eof;
    logic              w_emit_err;
    logic              w_crc_feed;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_take      = (r_state == ST_IDLE) && r_in_valid && w_out_free;
    assign w_oversize  = r_in_len > w_cfg.max_len;
    assign w_seen_inc  = r_seen + LEN_W'(1);
    assign w_seen_done = w_seen_inc >= r_len;
    assign w_need_pad  = r_len < LEN_W'(MIN_PAYLOAD);
    assign w_hdr_last  = r_idx == IDX_W'(HDR_BYTES - 1);
    assign w_pad_last  = r_cnt == CNT_W'(MIN_PAYLOAD - 1);
    assign w_fcs_last  = r_idx == IDX_W'(FCS_BYTES - 1);
    assign w_fcs_sh    = ~r_crc >> {r_idx[1:0], 3'b000};

    assign i_in.ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.cmd;
            r_in_dest <= i_in.dest_mac;
            r_in_type <= i_in.ether_type;
            r_in_len  <= i_in.payload_len;
            r_in_data <= i_in.data_byte;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && r_in_cmd == CMD_START && !w_oversize) begin
                    n_state = ST_HDR;
                end else if (w_take && r_in_cmd == CMD_DATA && r_open && w_seen_done) begin
                    n_state = w_need_pad ? ST_PAD : ST_FCS;
                end
            end
            ST_HDR: begin
                if (w_out_free && w_hdr_last) begin
                    if (r_len == '0) begin
                        n_state = w_need_pad ? ST_PAD : ST_FCS;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (w_out_free && w_pad_last) begin
                    n_state = ST_FCS;
                end
            end
            ST_FCS: begin
                if (w_out_free && w_fcs_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and emitted byte
    always_comb begin
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_hdr       = r_hdr;
        n_len       = r_len;
        n_seen      = r_seen;
        n_open      = r_open;
        n_crc       = r_crc;
        w_emit      = 1'b0;
        w_emit_byte = '0;
        w_emit_eof  = 1'b0;
        w_emit_err  = 1'b0;
        w_crc_feed  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && r_in_cmd == CMD_START) begin
                    n_crc  = CRC_INIT;
                    n_seen = '0;
                    n_open = 1'b0;
                    if (w_oversize) begin
                        n_len      = '0;
                        w_emit     = 1'b1;
                        w_emit_eof = 1'b1;
                        w_emit_err = 1'b1;
                    end else begin
                        n_len = r_in_len;
                        n_hdr = {r_in_dest, w_cfg.station_addr, r_in_type};
                        n_idx = '0;
                    end
                end else if (w_take && r_open) begin
                    w_emit      = 1'b1;
                    w_emit_byte = r_in_data;
                    w_crc_feed  = 1'b1;
                    n_seen      = w_seen_inc;
                    if (w_seen_done) begin
                        n_open = 1'b0;
                        n_idx  = '0;
                        n_cnt  = r_len[CNT_W-1:0];
                    end
                end
            end
            ST_HDR: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_byte = r_hdr[HDR_W-1 -: BYTE_W];
                    w_crc_feed  = 1'b1;
                    n_hdr       = {r_hdr[HDR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    n_idx       = r_idx + IDX_W'(1);
                    if (w_hdr_last) begin
                        n_idx  = '0;
                        n_cnt  = r_len[CNT_W-1:0];
                        n_open = r_len != '0;
                    end
                end
            end
            ST_PAD: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_crc_feed = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                    n_idx      = '0;
                end
            end
            ST_FCS: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_byte = w_fcs_sh[BYTE_W-1:0];
                    w_emit_eof  = w_fcs_last;
                    n_idx       = r_idx + IDX_W'(1);
                    if (w_fcs_last) begin
                        n_crc = CRC_INIT;
                        n_idx = '0;
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
        if (w_crc_feed) begin
            n_crc = crc32_byte(r_crc, w_emit_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_len   <= '0;
            r_seen  <= '0;
            r_open  <= 1'b0;
            r_crc   <= CRC_INIT;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_open  <= n_open;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    // result register: load whenever the slot is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_byte <= w_emit_byte;
            r_out_eof  <= w_emit_eof;
            r_out_err  <= w_emit_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.frame_byte     = r_out_byte;
    assign o_out.end_of_frame   = r_out_eof;
    assign o_out.oversize_error = r_out_err;

endmodule

>>> rtl/etxf_checker.sv
// Port-level checks of the framer, bound to the top level.
module etxf_checker import etxf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_eof,
    input logic              i_out_err
);

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_eof) && $stable(i_out_err))
        else $error("output beat changed while stalled");

    // a rejected frame is a single closing beat
    a_err_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_eof)
        else $error("oversize beat without end of frame");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_byte == '0)
        else $error("oversize beat carries a non-zero byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

endmodule

bind ethernet_tx_framer_crc32_core etxf_checker u_etxf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.frame_byte),
    .i_out_eof   (o_out.end_of_frame),
    .i_out_err   (o_out.oversize_error)
);
